>>> sv/gradient_polar_pseudocolor_assert.svh
`ifndef GRADIENT_POLAR_PSEUDOCOLOR_ASSERT_SVH
`define GRADIENT_POLAR_PSEUDOCOLOR_ASSERT_SVH

// cause implies effect in the same cycle
`define GPP_ASSERT_NOW(label, clk, rst_n, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |-> (effect)) \
    else $error(msg);

// cause implies effect in the next cycle
`define GPP_ASSERT_NEXT(label, clk, rst_n, cause, effect, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error(msg);

`endif

>>> sv/gpp_pkg.sv
package gpp_pkg;

  localparam int MAG_BITS_DEF   = 16;
  localparam int PHASE_BITS_DEF = 12;

  // angle as a 16-bit fraction of a turn
  localparam int ANG_BITS = 16;

  // saturation quotient bits below the binary point (q1.15)
  localparam int FRAC_BITS    = 15;
  localparam int DIV_CNT_BITS = 4;

  localparam logic [ANG_BITS-1:0] SHIFT_GREEN = 16'd21845;
  localparam logic [ANG_BITS-1:0] SHIFT_BLUE  = 16'd43691;

  // cosine series in q28
  localparam int T_W = 31;
  localparam logic [14:0] X_SCALE  = 15'd25736;
  localparam logic [28:0] Q28_ONE  = 29'h1000_0000;
  // exact reciprocals, ceil(2^k / d)
  localparam logic [27:0] RECIP_7  = 28'd153391690;   // k = 30
  localparam logic [29:0] RECIP_15 = 30'd572662307;   // k = 33
  localparam logic [28:0] RECIP_3  = 29'd357913942;   // k = 30

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_X,
    OP_X2,
    OP_T7,
    OP_P,
    OP_T15,
    OP_T3,
    OP_TFIN,
    OP_COS,
    OP_PROD,
    OP_SCALE,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } chan_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_INIT,
    ST_DIV,
    ST_X,
    ST_X2,
    ST_T7,
    ST_P7,
    ST_T15,
    ST_P15,
    ST_T3,
    ST_P3,
    ST_TFIN,
    ST_COS,
    ST_PROD,
    ST_SCALE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic  load;
    op_t   op;
    chan_t ch;
  } gpp_cmd_t;

endpackage

>>> sv/gradient_polar_pseudocolor.sv
// statistics item (in_kind low): taken while idle, busy stays low, next item next cycle
// color item: busy through divide, channel steps and emit; out_valid is registered from the emit state
// color items: no new item is taken until the last is through the 15-step divider and the
// shared multiplier running 12 steps per channel for three channels
// results cannot be stalled; synchronous active-low reset clears min/max and control
`include "gradient_polar_pseudocolor_assert.svh"

module gradient_polar_pseudocolor #(
  parameter int MAG_BITS   = gpp_pkg::MAG_BITS_DEF,
  parameter int PHASE_BITS = gpp_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input item channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_kind,
  input  logic                  in_start_of_frame,
  input  logic [MAG_BITS-1:0]   in_magnitude,
  input  logic [PHASE_BITS-1:0] in_phase,
  input  logic                  in_last_pixel,
  // result channel
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_last_out
);
  import gpp_pkg::*;

  // command word from the sequencer to the datapath:
  //   load  capture the item (and merge stats for a statistics item)
  //   op    which step of the divider / cosine series / channel math runs
  //   ch    which color channel the cosine steps work on
  gpp_cmd_t cmd;

  // sequencer: idle, saturation divide (one quotient bit per cycle),
  // then per channel a fixed series of multiplier steps, then an emit step
  gpp_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .busy    (busy),
    .cmd     (cmd)
  );

  // datapath: min/max tracking, restoring divider for the q1.15 saturation,
  // one shared 32x32 multiplier that evaluates the cosine polynomial in q28
  // with reciprocal multiplies for the constant divides, then 255*num>>31
  gpp_datapath #(
    .MAG_BITS   (MAG_BITS),
    .PHASE_BITS (PHASE_BITS)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_kind           (in_kind),
    .in_start_of_frame (in_start_of_frame),
    .in_magnitude      (in_magnitude),
    .in_phase          (in_phase),
    .in_last_pixel     (in_last_pixel),
    .out_valid         (out_valid),
    .out_red           (out_red),
    .out_green         (out_green),
    .out_blue          (out_blue),
    .out_last_out      (out_last_out)
  );

  // result strobe only shows up once the sequencer has gone back to idle
  `GPP_ASSERT_NOW(a_strobe_when_idle, clk, rst_n, out_valid, !busy, "strobe while busy")
  // strobe lasts exactly one cycle
  `GPP_ASSERT_NEXT(a_strobe_single, clk, rst_n, out_valid, !out_valid, "strobe held")
  // a color item starts the sequencer
  `GPP_ASSERT_NEXT(a_color_busy, clk, rst_n, start && !busy && in_kind, busy,
                   "color item not started")
  // a statistics item leaves the block ready
  `GPP_ASSERT_NEXT(a_stats_ready, clk, rst_n, start && !busy && !in_kind, !busy,
                   "statistics item stalled")

endmodule

>>> sv/gpp_ctrl.sv
module gpp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_kind,
  output logic             busy,
  output gpp_pkg::gpp_cmd_t cmd
);
  import gpp_pkg::*;

  state_t                  state_r, state_nxt;
  logic [DIV_CNT_BITS-1:0] cnt_r, cnt_nxt;
  chan_t                   ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ch_r    <= CH_RED;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ch_nxt    = ch_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_IDLE;
    cmd.ch    = ch_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        if (start && in_kind) begin
          state_nxt = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cmd.op    = OP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + DIV_CNT_BITS'(1);
        if (cnt_r == DIV_CNT_BITS'(FRAC_BITS - 1)) begin
          ch_nxt    = CH_RED;
          state_nxt = ST_X;
        end
      end
      ST_X: begin
        cmd.op    = OP_X;
        state_nxt = ST_X2;
      end
      ST_X2: begin
        cmd.op    = OP_X2;
        state_nxt = ST_T7;
      end
      ST_T7: begin
        cmd.op    = OP_T7;
        state_nxt = ST_P7;
      end
      ST_P7: begin
        cmd.op    = OP_P;
        state_nxt = ST_T15;
      end
      ST_T15: begin
        cmd.op    = OP_T15;
        state_nxt = ST_P15;
      end
      ST_P15: begin
        cmd.op    = OP_P;
        state_nxt = ST_T3;
      end
      ST_T3: begin
        cmd.op    = OP_T3;
        state_nxt = ST_P3;
      end
      ST_P3: begin
        cmd.op    = OP_P;
        state_nxt = ST_TFIN;
      end
      ST_TFIN: begin
        cmd.op    = OP_TFIN;
        state_nxt = ST_COS;
      end
      ST_COS: begin
        cmd.op    = OP_COS;
        state_nxt = ST_PROD;
      end
      ST_PROD: begin
        cmd.op    = OP_PROD;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        cmd.op = OP_SCALE;
        case (ch_r)
          CH_RED: begin
            ch_nxt    = CH_GREEN;
            state_nxt = ST_X;
          end
          CH_GREEN: begin
            ch_nxt    = CH_BLUE;
            state_nxt = ST_X;
          end
          default: begin
            state_nxt = ST_EMIT;
          end
        endcase
      end
      ST_EMIT: begin
        cmd.op    = OP_EMIT;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> sv/gpp_datapath.sv
module gpp_datapath #(
  parameter int MAG_BITS   = gpp_pkg::MAG_BITS_DEF,
  parameter int PHASE_BITS = gpp_pkg::PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gpp_pkg::gpp_cmd_t     cmd,
  input  logic                  in_kind,
  input  logic                  in_start_of_frame,
  input  logic [MAG_BITS-1:0]   in_magnitude,
  input  logic [PHASE_BITS-1:0] in_phase,
  input  logic                  in_last_pixel,
  output logic                  out_valid,
  output logic [7:0]            out_red,
  output logic [7:0]            out_green,
  output logic [7:0]            out_blue,
  output logic                  out_last_out
);
  import gpp_pkg::*;

  // frame statistics
  logic [MAG_BITS-1:0] min_r, max_r;

  // captured item
  logic [MAG_BITS-1:0] mag_r;
  logic [ANG_BITS-1:0] ang_r;
  logic                last_r;

  // saturation divider
  logic [MAG_BITS-1:0]  range_r, rem_r;
  logic [FRAC_BITS-1:0] quot_r;
  logic                 zero_r, sat_r;

  // cosine and channel
  logic [28:0]        x_r;
  logic [29:0]        x2_r, p_r;
  logic [T_W-1:0]     t_r;
  logic               neg_r;
  logic signed [16:0] cos_r;
  logic [31:0]        num_r;

  logic [7:0] red_r, green_r, blue_r;
  logic       last_out_r, valid_r;

  logic [MAG_BITS-1:0] range_w, diff_w;
  logic [MAG_BITS:0]   shl_w;
  logic                ge_w;
  logic [ANG_BITS-1:0] ang_ch_w;
  logic [1:0]          quad_w;
  logic [14:0]         rq_w;
  logic [15:0]         m_w;
  logic [28:0]         tc_w;
  logic [29:0]         rnd_w;
  logic [16:0]         c_w;
  logic [17:0]         omc_w;
  logic [31:0]         mul_a, mul_b;
  logic [63:0]         mul_p;
  logic [8:0]          scale_w;
  logic [7:0]          chan_w;

  assign range_w = (max_r > min_r) ? (max_r - min_r) : '0;
  assign diff_w  = (mag_r > min_r) ? (mag_r - min_r) : '0;

  assign shl_w = {rem_r, 1'b0};
  assign ge_w  = (shl_w >= {1'b0, range_r});

  always_comb begin
    case (cmd.ch)
      CH_GREEN: ang_ch_w = ang_r - SHIFT_GREEN;
      CH_BLUE:  ang_ch_w = ang_r - SHIFT_BLUE;
      default:  ang_ch_w = ang_r;
    endcase
  end

  // fold to the first quadrant, odd quadrants mirror
  assign quad_w = ang_ch_w[ANG_BITS-1 -: 2];
  assign rq_w   = quad_w[0] ? (15'd16384 - {1'b0, ang_ch_w[13:0]})
                            : {1'b0, ang_ch_w[13:0]};

  assign m_w = zero_r ? 16'd0 : (sat_r ? 16'd32768 : {1'b0, quot_r});

  // clamp and round q28 to q15
  assign tc_w  = t_r[T_W-1] ? 29'd0 : ((t_r > T_W'(Q28_ONE)) ? Q28_ONE : t_r[28:0]);
  assign rnd_w = 30'(tc_w) + 30'd4096;
  assign c_w   = rnd_w[29:13];

  assign omc_w = 18'd32768 - {cos_r[16], cos_r};

  always_comb begin
    case (cmd.op)
      OP_X: begin
        mul_a = 32'(rq_w);
        mul_b = 32'(X_SCALE);
      end
      OP_X2: begin
        mul_a = 32'(x_r);
        mul_b = 32'(x_r);
      end
      OP_T7: begin
        mul_a = 32'(x2_r[29:3]);
        mul_b = 32'(RECIP_7);
      end
      OP_P: begin
        mul_a = 32'(x2_r);
        mul_b = 32'(t_r[28:0]);
      end
      OP_T15: begin
        mul_a = 32'(p_r[29:1]);
        mul_b = 32'(RECIP_15);
      end
      OP_T3: begin
        mul_a = 32'(p_r[29:2]);
        mul_b = 32'(RECIP_3);
      end
      OP_PROD: begin
        mul_a = 32'(m_w);
        mul_b = 32'(omc_w[16:0]);
      end
      OP_SCALE: begin
        mul_a = num_r;
        mul_b = 32'd255;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign scale_w = mul_p[39:31];
  assign chan_w  = (scale_w > 9'd255) ? 8'd255 : scale_w[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r   <= '0;
      max_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      valid_r <= (cmd.op == OP_EMIT);
      if (cmd.load && !in_kind) begin
        if (in_start_of_frame) begin
          min_r <= in_magnitude;
          max_r <= in_magnitude;
        end else begin
          if (in_magnitude > max_r) begin
            max_r <= in_magnitude;
          end
          if (in_magnitude < min_r) begin
            min_r <= in_magnitude;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag_r  <= in_magnitude;
      ang_r  <= ANG_BITS'(in_phase) << (ANG_BITS - PHASE_BITS);
      last_r <= in_last_pixel;
    end
    case (cmd.op)
      OP_DIV_INIT: begin
        range_r <= range_w;
        rem_r   <= diff_w;
        quot_r  <= '0;
        zero_r  <= (range_w == '0);
        sat_r   <= (diff_w >= range_w);
      end
      OP_DIV_STEP: begin
        if (ge_w) begin
          rem_r <= MAG_BITS'(shl_w - {1'b0, range_r});
        end else begin
          rem_r <= shl_w[MAG_BITS-1:0];
        end
        quot_r <= {quot_r[FRAC_BITS-2:0], ge_w};
      end
      OP_X: begin
        x_r   <= mul_p[28:0];
        neg_r <= quad_w[1] ^ quad_w[0];
      end
      OP_X2:   x2_r <= mul_p[57:28];
      OP_T7:   t_r  <= T_W'(Q28_ONE) - T_W'(mul_p[58:30]);
      OP_P:    p_r  <= mul_p[57:28];
      OP_T15:  t_r  <= T_W'(Q28_ONE) - T_W'(mul_p[61:33]);
      OP_T3:   t_r  <= T_W'(Q28_ONE) - T_W'(mul_p[58:30]);
      OP_TFIN: t_r  <= T_W'(Q28_ONE) - T_W'(p_r[29:1]);
      OP_COS:  cos_r <= neg_r ? $signed(17'd0 - c_w) : $signed(c_w);
      OP_PROD: num_r <= 32'h8000_0000 - mul_p[31:0];
      OP_SCALE: begin
        case (cmd.ch)
          CH_RED:   red_r   <= chan_w;
          CH_GREEN: green_r <= chan_w;
          default:  blue_r  <= chan_w;
        endcase
      end
      OP_EMIT: last_out_r <= last_r;
      default: ;
    endcase
  end

  assign out_valid    = valid_r;
  assign out_red      = red_r;
  assign out_green    = green_r;
  assign out_blue     = blue_r;
  assign out_last_out = last_out_r;

endmodule

>>> dv/tb_gradient_polar_pseudocolor.sv
`timescale 1ns / 100ps

module tb_gradient_polar_pseudocolor;
  import gpp_pkg::*;

  localparam int MAG_W = MAG_BITS_DEF;
  localparam int PH_W  = PHASE_BITS_DEF;
  localparam int unsigned MAG_MAX = (1 << MAG_W) - 1;
  localparam int unsigned PH_MAX  = (1 << PH_W) - 1;

  // pass codes carried by in_kind
  localparam bit KIND_STATS = 1'b0;
  localparam bit KIND_COLOR = 1'b1;

  // cycle limit for the whole run, with a wide margin over the slowest run
  localparam int unsigned CYCLE_LIMIT = 500000;
  // wait after the last item, long enough for a color item to come out after its accept edge
  localparam int unsigned SETTLE_CYCLES = 80;

  localparam longint Q28 = longint'(Q28_ONE);

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } rgb_pixel_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_kind = 1'b0;
  logic             in_start_of_frame = 1'b0;
  logic [MAG_W-1:0] in_magnitude = '0;
  logic [PH_W-1:0]  in_phase = '0;
  logic             in_last_pixel = 1'b0;
  logic             out_valid;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic             out_last_out;

  // predictor copy of the frame statistics
  logic [MAG_W-1:0] lo_mag = '0;
  logic [MAG_W-1:0] hi_mag = '0;

  rgb_pixel_t  expected_colors[$];
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned colors_seen = 0;
  int unsigned cycle_count = 0;
  bit          gaps_on = 1'b1;

  gradient_polar_pseudocolor i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_start_of_frame(in_start_of_frame),
    .in_magnitude     (in_magnitude),
    .in_phase         (in_phase),
    .in_last_pixel    (in_last_pixel),
    .out_valid        (out_valid),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_last_out     (out_last_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // hard stop in case the block hangs or never drops busy
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_colors.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // color predictor
  // ---------------------------------------------------------------------------

  // cosine of a quarter-turn fraction r (0..16384), series in q28, result in q1.15
  function automatic longint quarter_cos(longint r);
    longint x, x2, t;
    x  = r * longint'(X_SCALE);
    x2 = (x * x) >>> 28;
    t  = Q28 - x2 / 56;
    t  = Q28 - ((x2 * t) >>> 28) / 30;
    t  = Q28 - ((x2 * t) >>> 28) / 12;
    t  = Q28 - ((x2 * t) >>> 28) / 2;
    if (t < 0) t = 0;
    if (t > Q28) t = Q28;
    return (t + 4096) >>> 13;
  endfunction

  // fold a 16-bit turn fraction onto the first quadrant, sine quadrants use 1/4 - r
  function automatic longint turn_cos(logic [ANG_BITS-1:0] ang);
    longint r;
    r = longint'(ang[13:0]);
    case (ang[15:14])
      2'd0: return quarter_cos(r);
      2'd1: return -quarter_cos(16384 - r);
      2'd2: return -quarter_cos(r);
      default: return quarter_cos(16384 - r);
    endcase
  endfunction

  // 255 * (1 - m * (1 - cos) / 2), truncated, with m in q1.15
  function automatic logic [7:0] channel_level(longint sat, logic [ANG_BITS-1:0] ang);
    longint c, num, v;
    c   = turn_cos(ang);
    num = (longint'(1) <<< 31) - sat * (32768 - c);
    if (num < 0) num = 0;
    v = (num * 255) >>> 31;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic rgb_pixel_t predict_color(logic [MAG_W-1:0] mag, logic [PH_W-1:0] ph,
                                               logic last);
    rgb_pixel_t px;
    longint span, diff, sat;
    logic [ANG_BITS-1:0] ang;
    // below-minimum pixels clamp to zero saturation, flat frames stay white
    span = (hi_mag > lo_mag) ? longint'(hi_mag) - longint'(lo_mag) : 0;
    diff = (mag > lo_mag) ? longint'(mag) - longint'(lo_mag) : 0;
    if (span == 0) begin
      sat = 0;
    end else begin
      sat = (diff <<< 15) / span;
      // above-maximum pixels saturate at 1.0
      if (sat > 32768) sat = 32768;
    end
    ang = ANG_BITS'(ph) << (ANG_BITS - PH_W);
    px.red   = channel_level(sat, ang);
    px.green = channel_level(sat, ang - SHIFT_GREEN);
    px.blue  = channel_level(sat, ang - SHIFT_BLUE);
    px.last  = last;
    return px;
  endfunction

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    $display("mismatch on result %0d, %s: got %0d, want %0d", colors_seen, what, got, want);
  endtask

  // results cannot be held off, so every strobe is taken at the edge ending its cycle
  always @(posedge clk) begin
    rgb_pixel_t want;
    if (rst_n && out_valid) begin
      if (expected_colors.size() == 0) begin
        report_mismatch("result with nothing expected", 1, 0);
      end else begin
        want = expected_colors.pop_front();
        if (out_red !== want.red) report_mismatch("red", out_red, want.red);
        if (out_green !== want.green) report_mismatch("green", out_green, want.green);
        if (out_blue !== want.blue) report_mismatch("blue", out_blue, want.blue);
        if (out_last_out !== want.last) report_mismatch("last_out", out_last_out, want.last);
      end
      colors_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  // send one pixel item; returns at the edge that accepted it, start left high
  task automatic send_pixel(bit kind, bit sof, logic [MAG_W-1:0] mag, logic [PH_W-1:0] ph,
                            bit last);
    int unsigned gap;
    if (gaps_on) begin
      // now and then a long gap, so the next item lands at any point of a color item
      gap = ($urandom_range(99) < 3) ? $urandom_range(70, 1) : 0;
      while (gap != 0 || $urandom_range(99) < 25) begin
        start <= 1'b0;
        @(posedge clk);
        if (gap != 0) gap--;
      end
    end
    start             <= 1'b1;
    in_kind           <= kind;
    in_start_of_frame <= sof;
    in_magnitude      <= mag;
    in_phase          <= ph;
    in_last_pixel     <= last;
    do @(posedge clk); while (busy);
    pixels_sent++;
    if (kind == KIND_STATS) begin
      // start flag reloads, otherwise merge into the running min and max
      if (sof) begin
        lo_mag = mag;
        hi_mag = mag;
      end else begin
        if (mag > hi_mag) hi_mag = mag;
        if (mag < lo_mag) lo_mag = mag;
      end
    end else begin
      expected_colors.push_back(predict_color(mag, ph, last));
    end
  endtask

  // sender holds off until every pending color has come out
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
  endtask

  // min and max are zero after reset, so the first color pixel is flat white
  task automatic test_reset_state();
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, 12'd1000, 1'b0);
    // start flag on a color item does nothing
    send_pixel(KIND_COLOR, 1'b1, '0, PH_MAX, 1'b1);
  endtask

  // statistics without a start flag merge into the reset values 0 and 0
  task automatic test_merge_from_reset();
    send_pixel(KIND_STATS, 1'b0, 16'd500, 12'd7, 1'b1);
    send_pixel(KIND_COLOR, 1'b0, 16'd250, 12'd0, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, 16'd500, 12'd2048, 1'b1);
  endtask

  // full magnitude span, phase at quadrant edges and both ends
  task automatic test_extremes();
    send_pixel(KIND_STATS, 1'b1, '0, '0, 1'b0);
    send_pixel(KIND_STATS, 1'b0, MAG_MAX, PH_MAX, 1'b1);
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, 12'd0, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, 12'd1024, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, 12'd2048, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, 12'd3072, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, PH_MAX, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, 16'd32768, 12'd1365, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, '0, PH_MAX, 1'b1);
  endtask

  // pixels below the minimum and above the maximum of the frame
  task automatic test_out_of_range();
    send_pixel(KIND_STATS, 1'b1, 16'd3000, 12'd100, 1'b0);
    send_pixel(KIND_STATS, 1'b0, 16'd1000, 12'd200, 1'b1);
    send_pixel(KIND_COLOR, 1'b0, 16'd10, 12'd512, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, 16'd60000, 12'd2730, 1'b0);
    send_pixel(KIND_COLOR, 1'b1, 16'd2000, 12'd3500, 1'b1);
  endtask

  // max equals min: every pixel comes out white
  task automatic test_flat_frame();
    send_pixel(KIND_STATS, 1'b1, 16'd777, 12'd0, 1'b1);
    send_pixel(KIND_COLOR, 1'b0, 16'd777, 12'd300, 1'b0);
    send_pixel(KIND_COLOR, 1'b0, MAG_MAX, 12'd2900, 1'b1);
    wait_for_drain();
  endtask

  // whole frames: a statistics pass then a color pass, with some noise and broken frames
  task automatic test_random_frames(int unsigned target);
    int unsigned goal, n_stats, n_color, lo_b, hi_b, tmp;
    bit          broken;
    logic [MAG_W-1:0] mag;
    goal = pixels_sent + target;
    while (pixels_sent < goal) begin
      if ($urandom_range(99) < 8) begin
        // stray item with every field random
        send_pixel($urandom_range(1), $urandom_range(1), $urandom_range(MAG_MAX),
                   $urandom_range(PH_MAX), $urandom_range(1));
        continue;
      end
      lo_b = $urandom_range(MAG_MAX);
      case ($urandom_range(3))
        0: hi_b = lo_b;  // flat frame
        1: begin
          // narrow frame, kept inside the magnitude range
          tmp  = lo_b + $urandom_range(255);
          hi_b = (tmp > MAG_MAX) ? MAG_MAX : tmp;
        end
        default: hi_b = $urandom_range(MAG_MAX);
      endcase
      if (lo_b > hi_b) begin
        tmp  = lo_b;
        lo_b = hi_b;
        hi_b = tmp;
      end
      // broken frame: statistics pass without start flag, start flags in the color pass
      broken  = ($urandom_range(99) < 10);
      n_stats = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
      for (int i = 0; i < n_stats; i++) begin
        if (i == 0) mag = lo_b;
        else if (i == 1) mag = hi_b;
        else mag = $urandom_range(hi_b, lo_b);
        send_pixel(KIND_STATS, (i == 0) && !broken, mag, $urandom_range(PH_MAX),
                   i == n_stats - 1);
      end
      n_color = $urandom_range(8, 1);
      for (int i = 0; i < n_color; i++) begin
        // mostly inside the frame range, some anywhere
        mag = ($urandom_range(7) == 0) ? $urandom_range(MAG_MAX) : $urandom_range(hi_b, lo_b);
        send_pixel(KIND_COLOR, broken ? $urandom_range(1) : 1'b0, mag, $urandom_range(PH_MAX),
                   i == n_color - 1);
      end
      if ($urandom_range(9) == 0) wait_for_drain();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_merge_from_reset();
    test_extremes();
    test_out_of_range();
    test_flat_frame();

    // random frames with idling, then a long stretch back to back
    gaps_on = 1'b1;
    test_random_frames(520);
    gaps_on = 1'b0;
    test_random_frames(200);

    start <= 1'b0;
    for (int i = 0; i < 2000 && expected_colors.size() != 0; i++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    // anything still queued never came out
    while (expected_colors.size() != 0) begin
      void'(expected_colors.pop_front());
      report_mismatch("missing result", 0, 1);
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
